// ----- rtl/fcd_pkg.sv -----
// Shared types and constants for the frame check and dispatch block.
package fcd_pkg;

  // Longest payload a frame may announce (default of the top-level parameter)
  localparam int unsigned MaxPayloadDef = 16;

  // Field and state widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned EventW = 2;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] RegStartValueAddr = 3'd0;
  localparam logic [ByteW-1:0]    StartValueRst     = 8'hFE;

  // Function byte that selects the LED on/off command
  localparam logic [ByteW-1:0] FuncLed = 8'h00;

  // Parse phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_FUNC,
    PH_DATA,
    PH_SUM
  } phase_e;

  // Verdict code
  typedef enum logic [EventW-1:0] {
    EV_ERROR   = 2'd0,
    EV_LED     = 2'd1,
    EV_UNKNOWN = 2'd2
  } event_e;

  // Verdict produced by the parser for one item
  typedef struct packed {
    logic             valid;
    event_e           event_code;
    logic [ByteW-1:0] function_code;
  } fcd_res_t;

endpackage

// ----- rtl/fcd_if.sv -----
// Valid/ready channel interfaces for received bytes and verdicts.
interface fcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       first_byte;

  modport source (output valid, output rx_byte, output first_byte, input ready);
  modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface fcd_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic [7:0] function_code;

  modport source (output valid, output event_code, output function_code, input ready);
  modport sink   (input valid, input event_code, input function_code, output ready);
endinterface

// ----- rtl/fcd_parser.sv -----
// Frame parser: phase, length count, running checksum and held function byte.
module fcd_parser #(
  parameter int unsigned MaxPayload = fcd_pkg::MaxPayloadDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [fcd_pkg::ByteW-1:0]   byte_i,
  input  logic                        first_i,
  input  logic [fcd_pkg::ByteW-1:0]   start_value_i,
  output fcd_pkg::fcd_res_t           res_o
);

  localparam logic [fcd_pkg::ByteW-1:0] MaxLen = fcd_pkg::ByteW'(MaxPayload);

  fcd_pkg::phase_e                 phase_q, phase_d;
  logic [fcd_pkg::CountW-1:0]      left_q, left_d;
  logic [fcd_pkg::ByteW-1:0]       sum_q, sum_d;
  logic [fcd_pkg::ByteW-1:0]       func_q, func_d;
  logic [fcd_pkg::ByteW-1:0]       sum_add;
  logic [fcd_pkg::CountW-1:0]      left_dec;

  assign sum_add  = sum_q + byte_i;
  assign left_dec = left_q - 1'b1;

  // Next state
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    sum_d   = sum_q;
    func_d  = func_q;
    if (first_i) begin
      func_d = '0;
      left_d = '0;
      if (byte_i != start_value_i) begin
        sum_d   = '0;
        phase_d = fcd_pkg::PH_IDLE;
      end else begin
        sum_d   = byte_i;
        phase_d = fcd_pkg::PH_LEN;
      end
    end else begin
      unique case (phase_q)
        fcd_pkg::PH_LEN: begin
          if (byte_i > MaxLen) begin
            phase_d = fcd_pkg::PH_IDLE;
          end else begin
            sum_d   = sum_add;
            left_d  = byte_i[fcd_pkg::CountW-1:0];
            phase_d = fcd_pkg::PH_FUNC;
          end
        end
        fcd_pkg::PH_FUNC: begin
          func_d  = byte_i;
          sum_d   = sum_add;
          phase_d = (left_q != '0) ? fcd_pkg::PH_DATA : fcd_pkg::PH_SUM;
        end
        fcd_pkg::PH_DATA: begin
          sum_d  = sum_add;
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = fcd_pkg::PH_SUM;
          end
        end
        fcd_pkg::PH_SUM: begin
          phase_d = fcd_pkg::PH_IDLE;
        end
        default: begin
          phase_d = fcd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Verdict for the current byte
  always_comb begin
    res_o.valid         = 1'b0;
    res_o.event_code    = fcd_pkg::EV_ERROR;
    res_o.function_code = '0;
    if (first_i) begin
      res_o.valid = (byte_i != start_value_i);
    end else begin
      unique case (phase_q)
        fcd_pkg::PH_LEN: begin
          res_o.valid = (byte_i > MaxLen);
        end
        fcd_pkg::PH_SUM: begin
          res_o.valid         = 1'b1;
          res_o.function_code = func_q;
          if (byte_i != sum_q) begin
            res_o.event_code = fcd_pkg::EV_ERROR;
          end else if (func_q == fcd_pkg::FuncLed) begin
            res_o.event_code = fcd_pkg::EV_LED;
          end else begin
            res_o.event_code = fcd_pkg::EV_UNKNOWN;
          end
        end
        default: begin
          res_o.valid = 1'b0;
        end
      endcase
    end
  end

  // State registers, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fcd_pkg::PH_IDLE;
      left_q  <= '0;
      sum_q   <= '0;
      func_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      func_q  <= func_d;
    end
  end

endmodule

// ----- rtl/frame_check_and_dispatch_core.sv -----
// Top level of the frame check and dispatch block.
//
// Usage: received bytes enter on in_i (rx_byte, first_byte), one item per
// byte; first_byte marks the start of a new buffer and restarts the parse.
// A frame is start byte, length, function byte, payload, checksum. For
// each frame one verdict item leaves on out_o: event_code (frame error,
// LED on/off command, unknown function) and the function byte (0 if none).
// Bytes after a verdict are dropped until the next first_byte.
// The start value is set through the APB port (register 0, reset 0xFE).
// Path: an accepted item sits in the input register, is parsed
// combinationally and its verdict is loaded into the result register for out_o.
// Throughput: one byte per cycle while out_o is not held off; the parse state
// loop is a single 8-bit add and compare per byte.
// Stalls: while out_o is held off, one more byte is taken into the input
// register; in_i.ready then drops until the result is taken.
// Reset: rst_ni clears the parse state, both registers' valid flags and
// restores the start value; no results are pending after reset.
module frame_check_and_dispatch_core #(
  parameter int unsigned MaxPayload = fcd_pkg::MaxPayloadDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [fcd_pkg::ApbDataW-1:0]   pwdata,
  output logic [fcd_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  // Byte and verdict channels
  fcd_byte_if.sink                       in_i,
  fcd_verdict_if.source                  out_o
);

  logic [fcd_pkg::ByteW-1:0] start_value_q;
  logic                      in_vld_q;
  logic [fcd_pkg::ByteW-1:0] in_byte_q;
  logic                      in_first_q;
  logic                      out_vld_q;
  fcd_pkg::event_e           out_event_q;
  logic [fcd_pkg::ByteW-1:0] out_func_q;
  logic                      advance;
  logic                      cfg_wr;
  fcd_pkg::fcd_res_t         res;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == fcd_pkg::RegStartValueAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_value_q <= fcd_pkg::StartValueRst;
    end else if (cfg_wr) begin
      start_value_q <= pwdata[fcd_pkg::ByteW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == fcd_pkg::RegStartValueAddr) begin
      prdata = fcd_pkg::ApbDataW'(start_value_q);
    end
  end

  // Handshake: the held byte moves on when the result register can take it
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.rx_byte;
      in_first_q <= in_i.first_byte;
    end
  end

  fcd_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .first_i       (in_first_q),
    .start_value_i (start_value_q),
    .res_o         (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_event_q <= res.event_code;
      out_func_q  <= res.function_code;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.event_code    = out_event_q;
  assign out_o.function_code = out_func_q;

endmodule
